FILE: hw/rtl/euqvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package euqvr_pkg;

    // Field widths of the item formats.
    localparam int VEC_W = 20;
    localparam int ANG_W = 16;

    // Angle reduction: angles are read in 1/256 degree, one turn is 92160 units.
    localparam int AEW       = 26;
    localparam int QTW       = 12;
    localparam int RW        = 30;
    localparam int TURN      = 92160;
    localparam int HALF_TURN = 46080;
    localparam int QTR_TURN  = 23040;
    // Reciprocal of one turn scaled by 2^32, rounded down.
    localparam int TURN_RCP  = 46603;

    // Rotator: Q30 x and y, z in 2^-16 degree.
    localparam int CW    = 33;
    localparam int ZW    = 26;
    localparam int STEPS = 18;
    localparam int SPS   = 3;
    localparam int NSTG  = STEPS / SPS;
    localparam logic signed [CW-1:0] GAIN = CW'(64'd652032874);

    // Sine and cosine in Q16, pair products, triple products, quaternion in Q24.
    localparam int SCW = 19;
    localparam int PPW = 2 * SCW;
    localparam int TPW = PPW + SCW;
    localparam int QW  = 28;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;
    typedef t_vec [2:0] t_vec3;

    typedef struct packed {
        t_vec vec_x;
        t_vec vec_y;
        t_vec vec_z;
        t_ang yaw_angle;
        t_ang roll_angle;
        t_ang pitch_angle;
    } t_in;

    typedef struct packed {
        t_vec rot_x;
        t_vec rot_y;
        t_vec rot_z;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_cord;

    // Lane 0 is yaw, lane 1 roll, lane 2 pitch.
    typedef struct packed {
        t_cord [2:0] ang;
        t_vec3       v;
    } t_ctok;

    typedef struct packed {
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        t_vec3                v;
    } t_quat;

    // Arctangent of 2^-i in 2^-16 degree.
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] val;
        case (idx)
            0:       val = ZW'(2949120);
            1:       val = ZW'(1740967);
            2:       val = ZW'(919879);
            3:       val = ZW'(466945);
            4:       val = ZW'(234379);
            5:       val = ZW'(117304);
            6:       val = ZW'(58666);
            7:       val = ZW'(29335);
            8:       val = ZW'(14668);
            9:       val = ZW'(7334);
            10:      val = ZW'(3667);
            11:      val = ZW'(1833);
            12:      val = ZW'(917);
            13:      val = ZW'(458);
            14:      val = ZW'(229);
            15:      val = ZW'(115);
            16:      val = ZW'(57);
            17:      val = ZW'(29);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/euqvr_angle.sv
`timescale 1ns / 1ps
`default_nettype none
module euqvr_angle (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  euqvr_pkg::t_in      i_item,
    output logic                o_valid,
    output euqvr_pkg::t_ctok    o_tok
);
    import euqvr_pkg::*;

    localparam logic signed [AEW+18-1:0] RCP     = (AEW+18)'(TURN_RCP);
    localparam logic signed [RW-1:0]     TURN_S  = RW'(TURN);
    localparam logic signed [RW-1:0]     HALF_S  = RW'(HALF_TURN);
    localparam logic signed [RW-1:0]     QTR_S   = RW'(QTR_TURN);
    localparam logic signed [RW-1:0]     THREE_H = RW'(3 * HALF_TURN);

    logic [2:0]              r_valid;
    logic signed [AEW-1:0]   r_a   [3];
    logic signed [QTW-1:0]   r_q   [3];
    logic signed [RW-1:0]    r_r   [3];
    t_vec3                   r_vec1, r_vec2;
    logic signed [AEW-1:0]   a_ext [3];
    logic signed [AEW+18-1:0] prod [3];
    logic signed [RW-1:0]    n_r   [3];
    t_ctok                   n_tok, r_tok;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end
    assign o_valid = r_valid[2];

    // Stage one: quotient estimate by multiplication with the reciprocal of a turn.
    always_comb begin
        a_ext[0] = AEW'(i_item.yaw_angle);
        a_ext[1] = AEW'(i_item.roll_angle);
        a_ext[2] = AEW'(i_item.pitch_angle);
        for (int k = 0; k < 3; k++) begin
            prod[k] = (AEW+18)'(a_ext[k]) * RCP;
        end
    end

    // Stage two: remainder, then stage three: fold into the range of the rotator.
    always_comb begin
        logic signed [RW-1:0] raw;
        logic signed [RW-1:0] rr;
        for (int k = 0; k < 3; k++) begin
            raw = RW'(r_a[k]) - RW'(r_q[k]) * TURN_S;
            n_r[k] = raw;
        end
        n_tok.v = r_vec2;
        for (int k = 0; k < 3; k++) begin
            raw = r_r[k];
            if (raw < -HALF_S) begin
                rr = raw + TURN_S;
            end else if (raw >= THREE_H) begin
                rr = raw - (TURN_S <<< 1);
            end else if (raw >= HALF_S) begin
                rr = raw - TURN_S;
            end else begin
                rr = raw;
            end
            n_tok.ang[k].neg = 1'b0;
            if (rr > QTR_S) begin
                rr = rr - HALF_S;
                n_tok.ang[k].neg = 1'b1;
            end else if (rr < -QTR_S) begin
                rr = rr + HALF_S;
                n_tok.ang[k].neg = 1'b1;
            end
            n_tok.ang[k].z = ZW'(rr <<< 8);
            n_tok.ang[k].x = GAIN;
            n_tok.ang[k].y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= a_ext[k];
                r_q[k] <= prod[k][AEW+18-1:32];
                r_r[k] <= n_r[k];
            end
            r_vec1 <= {i_item.vec_x, i_item.vec_y, i_item.vec_z};
            r_vec2 <= r_vec1;
            r_tok  <= n_tok;
        end
    end
    assign o_tok = r_tok;

endmodule
`default_nettype wire

FILE: hw/rtl/euqvr_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module euqvr_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  euqvr_pkg::t_ctok  i_tok,
    output logic              o_valid,
    output euqvr_pkg::t_ctok  o_tok
);
    import euqvr_pkg::*;

    logic  r_valid;
    t_ctok n_tok, r_tok;

    // A few rotation steps for each of the three angle lanes.
    always_comb begin
        logic signed [CW-1:0] x, y, dx, dy;
        logic signed [ZW-1:0] z;
        n_tok = i_tok;
        for (int k = 0; k < 3; k++) begin
            x = i_tok.ang[k].x;
            y = i_tok.ang[k].y;
            z = i_tok.ang[k].z;
            for (int j = 0; j < SPS; j++) begin
                dx = y >>> (STAGE * SPS + j);
                dy = x >>> (STAGE * SPS + j);
                if (!z[ZW-1]) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q16(STAGE * SPS + j);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q16(STAGE * SPS + j);
                end
            end
            n_tok.ang[k].x = x;
            n_tok.ang[k].y = y;
            n_tok.ang[k].z = z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule
`default_nettype wire

FILE: hw/rtl/euqvr_quat.sv
`timescale 1ns / 1ps
`default_nettype none
module euqvr_quat (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  euqvr_pkg::t_ctok  i_tok,
    output logic              o_valid,
    output euqvr_pkg::t_quat  o_quat
);
    import euqvr_pkg::*;

    localparam logic signed [CW-1:0]  RND14 = CW'(64'h2000);
    localparam logic signed [TPW:0]   RND24 = (TPW+1)'(64'h800000);

    logic [3:0]             r_valid;
    logic signed [SCW-1:0]  r_s [3];
    logic signed [SCW-1:0]  r_c [3];
    logic signed [SCW-1:0]  n_s [3];
    logic signed [SCW-1:0]  n_c [3];
    logic signed [PPW-1:0]  r_cycp, r_sysp, r_cysp, r_sycp;
    logic signed [SCW-1:0]  r_cr, r_sr;
    logic signed [TPW-1:0]  r_t [8];
    t_vec3                  r_v1, r_v2, r_v3;
    t_quat                  n_quat, r_quat;

    // Stage one: round Q30 to Q16 and apply the half-turn sign.
    always_comb begin
        logic signed [CW-1:0] cx, sy;
        for (int k = 0; k < 3; k++) begin
            cx = (i_tok.ang[k].x + RND14) >>> 14;
            sy = (i_tok.ang[k].y + RND14) >>> 14;
            n_c[k] = i_tok.ang[k].neg ? -cx[SCW-1:0] : cx[SCW-1:0];
            n_s[k] = i_tok.ang[k].neg ? -sy[SCW-1:0] : sy[SCW-1:0];
        end
    end

    // Stage four: pair the triple products and round to Q24.
    always_comb begin
        logic signed [TPW:0] sw, sx, sy, sz;
        sw = (TPW+1)'(r_t[0]) + (TPW+1)'(r_t[1]) + RND24;
        sx = (TPW+1)'(r_t[2]) + (TPW+1)'(r_t[3]) + RND24;
        sy = (TPW+1)'(r_t[4]) - (TPW+1)'(r_t[5]) + RND24;
        sz = (TPW+1)'(r_t[6]) - (TPW+1)'(r_t[7]) + RND24;
        sw = sw >>> 24;
        sx = sx >>> 24;
        sy = sy >>> 24;
        sz = sz >>> 24;
        n_quat.qw = sw[QW-1:0];
        n_quat.qx = sx[QW-1:0];
        n_quat.qy = sy[QW-1:0];
        n_quat.qz = sz[QW-1:0];
        n_quat.v  = r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= n_s[k];
                r_c[k] <= n_c[k];
            end
            r_v1 <= i_tok.v;
            // Stage two: yaw and pitch pair products.
            r_cycp <= PPW'(r_c[0]) * PPW'(r_c[2]);
            r_sysp <= PPW'(r_s[0]) * PPW'(r_s[2]);
            r_cysp <= PPW'(r_c[0]) * PPW'(r_s[2]);
            r_sycp <= PPW'(r_s[0]) * PPW'(r_c[2]);
            r_cr   <= r_c[1];
            r_sr   <= r_s[1];
            r_v2   <= r_v1;
            // Stage three: times the roll terms.
            r_t[0] <= TPW'(r_cycp) * TPW'(r_cr);
            r_t[1] <= TPW'(r_sysp) * TPW'(r_sr);
            r_t[2] <= TPW'(r_cysp) * TPW'(r_cr);
            r_t[3] <= TPW'(r_sycp) * TPW'(r_sr);
            r_t[4] <= TPW'(r_sycp) * TPW'(r_cr);
            r_t[5] <= TPW'(r_cysp) * TPW'(r_sr);
            r_t[6] <= TPW'(r_cycp) * TPW'(r_sr);
            r_t[7] <= TPW'(r_sysp) * TPW'(r_cr);
            r_v3   <= r_v2;
            r_quat <= n_quat;
        end
    end

    assign o_valid = r_valid[3];
    assign o_quat  = r_quat;

endmodule
`default_nettype wire

FILE: hw/rtl/euqvr_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
module euqvr_rotate (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  euqvr_pkg::t_quat  i_quat,
    output logic              o_valid,
    output euqvr_pkg::t_out   o_item
);
    import euqvr_pkg::*;

    localparam int SQW = 2 * QW;
    localparam int UVW = QW + VEC_W;
    localparam int DW  = VEC_W + 2;
    localparam int FW  = VEC_W + QW + 5;
    localparam int RSW = FW - 24;
    localparam logic signed [SQW+1:0] RND_A = (SQW+2)'(64'h800000);
    localparam logic signed [UVW+1:0] RND_D = (UVW+2)'(64'h800000);
    localparam logic signed [FW-1:0]  RND_F = FW'(64'h800000);
    localparam logic signed [RSW-1:0] MAXV  = RSW'((64'd1 << (VEC_W - 1)) - 64'd1);
    localparam logic signed [RSW-1:0] MINV  = ~MAXV;

    logic [3:0]             r_valid;
    // Stage one registers.
    logic signed [SQW-1:0]  r_sq [4];
    logic signed [UVW-1:0]  r_uv [3][3];
    logic signed [QW-1:0]   r_w1, r_w2;
    logic signed [QW-1:0]   r_u1 [3];
    logic signed [QW-1:0]   r_u2 [3];
    t_vec3                  r_v1, r_v2;
    // Stage two registers.
    logic signed [QW-1:0]   r_a;
    logic signed [DW-1:0]   r_d;
    logic signed [DW-1:0]   r_cr [3];
    logic signed [QW-1:0]   n_a;
    logic signed [DW-1:0]   n_d;
    logic signed [DW-1:0]   n_cr [3];
    // Stage three registers.
    logic signed [FW-1:0]   r_pa [3];
    logic signed [FW-1:0]   r_pd [3];
    logic signed [FW-1:0]   r_pw [3];
    t_out                   n_out, r_out;
    logic signed [QW-1:0]   u_in [3];

    assign u_in[0] = i_quat.qx;
    assign u_in[1] = i_quat.qy;
    assign u_in[2] = i_quat.qz;

    // Stage two: norm term, dot product and cross product, rounded.
    always_comb begin
        logic signed [SQW+1:0] sa;
        logic signed [UVW+1:0] sd, s0, s1, s2;
        sa = (SQW+2)'(r_sq[0]) - (SQW+2)'(r_sq[1]) - (SQW+2)'(r_sq[2])
           - (SQW+2)'(r_sq[3]) + RND_A;
        sd = (UVW+2)'(r_uv[0][0]) + (UVW+2)'(r_uv[1][1]) + (UVW+2)'(r_uv[2][2]) + RND_D;
        s0 = (UVW+2)'(r_uv[1][2]) - (UVW+2)'(r_uv[2][1]) + RND_D;
        s1 = (UVW+2)'(r_uv[2][0]) - (UVW+2)'(r_uv[0][2]) + RND_D;
        s2 = (UVW+2)'(r_uv[0][1]) - (UVW+2)'(r_uv[1][0]) + RND_D;
        sa = sa >>> 24;
        sd = sd >>> 24;
        s0 = s0 >>> 24;
        s1 = s1 >>> 24;
        s2 = s2 >>> 24;
        n_a     = sa[QW-1:0];
        n_d     = sd[DW-1:0];
        n_cr[0] = s0[DW-1:0];
        n_cr[1] = s1[DW-1:0];
        n_cr[2] = s2[DW-1:0];
    end

    // Stage four: combine, round to whole units and saturate.
    always_comb begin
        logic signed [FW-1:0]  s;
        logic signed [RSW-1:0] r;
        t_vec                  res [3];
        for (int k = 0; k < 3; k++) begin
            s = r_pa[k] + (r_pd[k] <<< 1) + (r_pw[k] <<< 1) + RND_F;
            s = s >>> 24;
            r = s[RSW-1:0];
            if (r > MAXV) begin
                res[k] = MAXV[VEC_W-1:0];
            end else if (r < MINV) begin
                res[k] = MINV[VEC_W-1:0];
            end else begin
                res[k] = r[VEC_W-1:0];
            end
        end
        n_out.rot_x = res[0];
        n_out.rot_y = res[1];
        n_out.rot_z = res[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage one: squares and all products of u with v.
            r_sq[0] <= SQW'(i_quat.qw) * SQW'(i_quat.qw);
            for (int i = 0; i < 3; i++) begin
                r_sq[i+1] <= SQW'(u_in[i]) * SQW'(u_in[i]);
                for (int j = 0; j < 3; j++) begin
                    r_uv[i][j] <= UVW'(u_in[i]) * UVW'(i_quat.v[2-j]);
                end
                r_u1[i] <= u_in[i];
                r_u2[i] <= r_u1[i];
            end
            r_w1 <= i_quat.qw;
            r_v1 <= i_quat.v;
            // Stage two.
            r_a  <= n_a;
            r_d  <= n_d;
            for (int k = 0; k < 3; k++) begin
                r_cr[k] <= n_cr[k];
            end
            r_w2 <= r_w1;
            r_v2 <= r_v1;
            // Stage three: the three terms of each output component.
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= FW'(r_a) * FW'(r_v2[2-k]);
                r_pd[k] <= FW'(r_d) * FW'(r_u2[k]);
                r_pw[k] <= FW'(r_w2) * FW'(r_cr[k]);
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid[3];
    assign o_item  = r_out;

endmodule
`default_nettype wire

FILE: hw/rtl/euler_quaternion_vector_rotate_unit.sv
// Euler-angle vector rotator.
// An input item carries a vector (x, y, z) and yaw, roll and pitch angles in
// 1/128 degree. The block builds the quaternion of the three angles and
// returns the vector rotated by it, saturated to the vector format.
// Both channels use valid and ready; an item moves on a rising edge at which
// both are high. One item is accepted every cycle while the output side takes
// results. The pipeline has three angle reduction stages, six rotator stages
// of three steps each, four quaternion stages and four rotation stages, the
// last of which is the output register.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and o_ready falls; no item is lost or repeated.
// A synchronous active-low reset empties the pipeline; no result is shown
// until new items arrive. The block keeps no state between items.
`timescale 1ns / 1ps
`default_nettype none
module euler_quaternion_vector_rotate_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  euqvr_pkg::t_in   i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output euqvr_pkg::t_out  o_item
);
    import euqvr_pkg::*;

    logic  en;
    logic  ang_valid, quat_valid;
    t_ctok ang_tok;
    t_quat quat;
    logic  cv [NSTG+1];
    t_ctok ct [NSTG+1];

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    euqvr_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (ang_valid),
        .o_tok   (ang_tok)
    );

    assign cv[0] = ang_valid;
    assign ct[0] = ang_tok;

    // Sine and cosine rotator, a few steps per stage.
    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        euqvr_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[g]),
            .i_tok   (ct[g]),
            .o_valid (cv[g+1]),
            .o_tok   (ct[g+1])
        );
    end

    euqvr_quat u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cv[NSTG]),
        .i_tok   (ct[NSTG]),
        .o_valid (quat_valid),
        .o_quat  (quat)
    );

    euqvr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (quat_valid),
        .i_quat  (quat),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

FILE: sim/euler_quaternion_vector_rotate_unit_test.sv
`timescale 1ns / 1ps
module euler_quaternion_vector_rotate_unit_test;
    import euqvr_pkg::*;

    localparam int LATENCY = 17;

    // Idle patterns: 0 none, 1 sender, 2 receiver, 3 both.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_item;
    logic  o_valid;
    logic  i_ready;
    t_out  o_item;

    t_in   pending_items[$];
    t_out  expected_rotations[$];
    int    idle_mode;
    bit    hold_sender;
    bit    failed;

    // Acceptance as seen at the last rising edge.
    bit    o_ready_seen;

    euler_quaternion_vector_rotate_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Arctangent of 2^-i in 2^-16 degree.
    function automatic longint atan_step(input int idx);
        longint tbl[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115, 57, 29};
        return tbl[idx];
    endfunction

    function automatic longint round_q(input longint v, input int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    // Sine and cosine in Q16 of a half angle given in 1/256 degree.
    task automatic half_angle_trig(input longint a, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        r = a % 92160;
        flip = 0;
        x = 652032874;
        y = 0;
        if (r < 0) r += 92160;
        if (r >= 46080) r -= 92160;
        if (r > 23040) begin
            r -= 46080;
            flip = 1;
        end else if (r < -23040) begin
            r += 46080;
            flip = 1;
        end
        z = r * 256;
        for (int i = 0; i < 18; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end else begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        c = round_q(x, 14);
        s = round_q(y, 14);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endtask

    function automatic t_vec clamp_vec(input longint v);
        if (v > 524287) return t_vec'(524287);
        if (v < -524288) return t_vec'(-524288);
        return t_vec'(v);
    endfunction

    // Expected rotation of one item.
    task automatic rotate_vector(input t_in it, output t_out res);
        longint v[3];
        longint u[3];
        longint cr[3];
        longint rr[3];
        longint sy, cy, sr, cr_, sp, cp, w, a, d;
        v[0] = it.vec_x;
        v[1] = it.vec_y;
        v[2] = it.vec_z;
        half_angle_trig(longint'(it.yaw_angle), sy, cy);
        half_angle_trig(longint'(it.roll_angle), sr, cr_);
        half_angle_trig(longint'(it.pitch_angle), sp, cp);
        w    = round_q(cy * cp * cr_ + sy * sp * sr, 24);
        u[0] = round_q(cy * sp * cr_ + sy * cp * sr, 24);
        u[1] = round_q(sy * cp * cr_ - cy * sp * sr, 24);
        u[2] = round_q(cy * cp * sr - sy * sp * cr_, 24);
        a = round_q(w * w - u[0] * u[0] - u[1] * u[1] - u[2] * u[2], 24);
        d = round_q(u[0] * v[0] + u[1] * v[1] + u[2] * v[2], 24);
        cr[0] = round_q(u[1] * v[2] - u[2] * v[1], 24);
        cr[1] = round_q(u[2] * v[0] - u[0] * v[2], 24);
        cr[2] = round_q(u[0] * v[1] - u[1] * v[0], 24);
        for (int k = 0; k < 3; k++)
            rr[k] = round_q(a * v[k] + 2 * d * u[k] + 2 * w * cr[k], 24);
        res.rot_x = clamp_vec(rr[0]);
        res.rot_y = clamp_vec(rr[1]);
        res.rot_z = clamp_vec(rr[2]);
    endtask

    function automatic t_in make_item(input int vx, input int vy, input int vz,
                                      input int yaw, input int roll, input int pitch);
        t_in it;
        it.vec_x = t_vec'(vx);
        it.vec_y = t_vec'(vy);
        it.vec_z = t_vec'(vz);
        it.yaw_angle = t_ang'(yaw);
        it.roll_angle = t_ang'(roll);
        it.pitch_angle = t_ang'(pitch);
        return it;
    endfunction

    // Random vector component: mostly full range, sometimes near zero or the rails.
    function automatic int rand_vec();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 64) - 32;
            1: return 524287 - $urandom_range(0, 3);
            2: return -524288 + $urandom_range(0, 3);
            default: return int'(t_vec'($urandom));
        endcase
    endfunction

    function automatic int rand_ang();
        case ($urandom_range(0, 5))
            0: return 128 * 90 * ($urandom_range(0, 4) - 2);
            1: return $urandom_range(0, 8) - 4;
            default: return int'(t_ang'($urandom));
        endcase
    endfunction

    function automatic bit idle_now(input bit sender);
        int pct;
        pct = 0;
        if (idle_mode == IDLE_BOTH) pct = 14;
        else if (sender && idle_mode == IDLE_SEND) pct = 50;
        else if (!sender && idle_mode == IDLE_RECV) pct = 50;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Clock.
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: presents items from the queue at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready_seen)) begin
            if (pending_items.size() > 0 && !hold_sender && !idle_now(1'b1)) begin
                i_item  <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= i_rst_n && !idle_now(1'b0);
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge i_clk) begin
        t_out exp_res;
        o_ready_seen <= !i_rst_n || !(i_valid && !o_ready);
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rotate_vector(i_item, exp_res);
                expected_rotations.push_back(exp_res);
            end
            if (o_valid && i_ready) begin
                if (expected_rotations.size() == 0) begin
                    $error("result with no item pending: %0d %0d %0d",
                           o_item.rot_x, o_item.rot_y, o_item.rot_z);
                    failed = 1;
                end else begin
                    exp_res = expected_rotations.pop_front();
                    if (o_item.rot_x !== exp_res.rot_x) begin
                        $error("rot_x expected %0d actual %0d", exp_res.rot_x, o_item.rot_x);
                        failed = 1;
                    end
                    if (o_item.rot_y !== exp_res.rot_y) begin
                        $error("rot_y expected %0d actual %0d", exp_res.rot_y, o_item.rot_y);
                        failed = 1;
                    end
                    if (o_item.rot_z !== exp_res.rot_z) begin
                        $error("rot_z expected %0d actual %0d", exp_res.rot_z, o_item.rot_z);
                        failed = 1;
                    end
                end
            end
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_rotations.size() > 0) @(posedge i_clk);
    endtask

    // Stimulus.
    initial begin
        failed = 0;
        idle_mode = IDLE_NONE;
        hold_sender = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_item = '0;
        o_ready_seen = 1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes of the fields, quarter and half turns, wrapping.
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(524287, -524288, 1, 0, 0, 0));
        pending_items.push_back(make_item(524287, 524287, 524287, 32767, 32767, 32767));
        pending_items.push_back(make_item(-524288, -524288, -524288, -32768, -32768, -32768));
        pending_items.push_back(make_item(524287, 0, 0, 11520, 0, 0));
        pending_items.push_back(make_item(0, 524287, 0, 0, 11520, 0));
        pending_items.push_back(make_item(0, 0, 524287, 0, 0, 11520));
        pending_items.push_back(make_item(4096, 8192, -4096, 23040, -23040, 0));
        pending_items.push_back(make_item(-524288, 524287, -524288, 5760, 5760, 5760));
        pending_items.push_back(make_item(524287, 524287, -524288, -11520, 17280, -17280));
        pending_items.push_back(make_item(1000, -1000, 2000, 1, -1, 11521));
        pending_items.push_back(make_item(-1, -1, -1, 30000, -30000, 23041));
        pending_items.push_back(make_item(524287, 524287, 524287, 5760, 0, 0));
        pending_items.push_back(make_item(-524288, -524288, 524287, 0, 5760, -5760));
        drain();

        // Sender pauses until every result is back.
        hold_sender = 1;
        for (int i = 0; i < 40; i++)
            pending_items.push_back(make_item(rand_vec(), rand_vec(), rand_vec(),
                                              rand_ang(), rand_ang(), rand_ang()));
        while (expected_rotations.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
        hold_sender = 0;
        drain();

        // Random phases under each idle pattern.
        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = ph % 4;
            for (int i = 0; i < 225; i++)
                pending_items.push_back(make_item(rand_vec(), rand_vec(), rand_vec(),
                                                  rand_ang(), rand_ang(), rand_ang()));
            drain();
        end

        repeat (LATENCY + 5) @(posedge i_clk);
        if (!failed && expected_rotations.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Timeout.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/euqvr_pkg.sv
hw/rtl/euqvr_angle.sv
hw/rtl/euqvr_cordic_stage.sv
hw/rtl/euqvr_quat.sv
hw/rtl/euqvr_rotate.sv
hw/rtl/euler_quaternion_vector_rotate_unit.sv
sim/euler_quaternion_vector_rotate_unit_test.sv
